@@ sv/pbm_pkg.sv @@
// Package: shared constants and types for the pixel block mosaic.
`default_nettype none
package pbm_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIXEL_BITS = 32;

  // counter and address widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CMP_W  = 16;

  // register field widths
  localparam int FW_W   = 12;
  localparam int FH_W   = 13;
  localparam int BS_W   = 8;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BLOCK_SIZE   = 2'd2;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);
  localparam logic [BS_W-1:0] BS_RESET = BS_W'(1);

  // where a pixel's output value comes from
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_DIRECT = 2'd0;  // block corner on a band's first row
  localparam kind_t KIND_READ   = 2'd1;  // line store read-back
  localparam kind_t KIND_HOLD   = 2'd2;  // same block as previous pixel

  typedef struct packed {
    kind_t kind;
    logic  frame_end;
  } pix_ctrl_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [COL_W-1:0] addr;
  } ram_req_t;

endpackage
`default_nettype wire

@@ sv/pbm_line_ram.sv @@
// Line store: one sampled pixel per block column, registered read.
`default_nettype none
module pbm_line_ram
  import pbm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire ram_req_t              req_i,
  input  wire logic [PIXEL_BITS-1:0] wdata_i,
  output logic      [PIXEL_BITS-1:0] rdata_o
);

  logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/pbm_pos.sv @@
// Position tracking: column, row, block phases and line store requests.
`default_nettype none
module pbm_pos
  import pbm_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_acc_i,
  input  wire logic            frame_start_i,
  input  wire logic [FW_W-1:0] frame_width_i,
  input  wire logic [FH_W-1:0] frame_height_i,
  input  wire logic [BS_W-1:0] block_size_i,
  output pix_ctrl_t            ctrl_o,
  output ram_req_t             ram_req_o
);

  logic [COL_W-1:0] col_q, col_d, col_e;
  logic [ROW_W-1:0] row_q, row_d, row_e;
  logic [BS_W-1:0]  cph_q, cph_d, cph_e;
  logic [BS_W-1:0]  rph_q, rph_d, rph_e;
  logic [COL_W-1:0] bidx_q, bidx_d, bidx_e;

  logic [CMP_W-1:0] w_lim, h_lim;
  logic [BS_W:0]    bs_lim;
  logic             last_col, last_row, cph_wrap, rph_wrap;

  // frame start clears the position before this pixel is handled
  assign col_e  = frame_start_i ? '0 : col_q;
  assign row_e  = frame_start_i ? '0 : row_q;
  assign cph_e  = frame_start_i ? '0 : cph_q;
  assign rph_e  = frame_start_i ? '0 : rph_q;
  assign bidx_e = frame_start_i ? '0 : bidx_q;

  always_comb begin
    if (frame_width_i == '0) begin
      w_lim = CMP_W'(1);
    end else if (CMP_W'(frame_width_i) > CMP_W'(MAX_WIDTH)) begin
      w_lim = CMP_W'(MAX_WIDTH);
    end else begin
      w_lim = CMP_W'(frame_width_i);
    end
    if (frame_height_i == '0) begin
      h_lim = CMP_W'(1);
    end else if (CMP_W'(frame_height_i) > CMP_W'(MAX_HEIGHT)) begin
      h_lim = CMP_W'(MAX_HEIGHT);
    end else begin
      h_lim = CMP_W'(frame_height_i);
    end
    bs_lim = (block_size_i == '0) ? (BS_W+1)'(1) : {1'b0, block_size_i};
  end

  assign last_col = (CMP_W'(col_e) + CMP_W'(1)) >= w_lim;
  assign last_row = (CMP_W'(row_e) + CMP_W'(1)) >= h_lim;
  assign cph_wrap = ({1'b0, cph_e} + (BS_W+1)'(1)) >= bs_lim;
  assign rph_wrap = ({1'b0, rph_e} + (BS_W+1)'(1)) >= bs_lim;

  always_comb begin
    if (cph_e != '0) begin
      ctrl_o.kind = KIND_HOLD;
    end else if (rph_e == '0) begin
      ctrl_o.kind = KIND_DIRECT;
    end else begin
      ctrl_o.kind = KIND_READ;
    end
    ctrl_o.frame_end = last_col & last_row;
    ram_req_o.we   = in_acc_i & (cph_e == '0) & (rph_e == '0);
    ram_req_o.re   = in_acc_i & (cph_e == '0) & (rph_e != '0);
    ram_req_o.addr = bidx_e;
  end

  always_comb begin
    col_d  = col_e;
    row_d  = row_e;
    cph_d  = cph_e;
    rph_d  = rph_e;
    bidx_d = bidx_e;
    if (!last_col) begin
      col_d = col_e + COL_W'(1);
      if (cph_wrap) begin
        cph_d  = '0;
        bidx_d = bidx_e + COL_W'(1);
      end else begin
        cph_d = cph_e + BS_W'(1);
      end
    end else begin
      col_d  = '0;
      cph_d  = '0;
      bidx_d = '0;
      if (!last_row) begin
        row_d = row_e + ROW_W'(1);
        rph_d = rph_wrap ? '0 : rph_e + BS_W'(1);
      end else begin
        row_d = '0;
        rph_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      cph_q  <= '0;
      rph_q  <= '0;
      bidx_q <= '0;
    end else if (in_acc_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      cph_q  <= cph_d;
      rph_q  <= rph_d;
      bidx_q <= bidx_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/pbm_out.sv @@
// Output pipeline: read-data stage, held block value and output register.
`default_nettype none
module pbm_out
  import pbm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_acc_i,
  input  wire logic [PIXEL_BITS-1:0] pixel_i,
  input  wire pix_ctrl_t             ctrl_i,
  input  wire logic [PIXEL_BITS-1:0] rdata_i,
  input  wire logic                  out_stall_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  output logic      [PIXEL_BITS-1:0] pixel_o,
  output logic                       frame_end_o
);

  logic                  a_vld_q, a_vld_d;
  logic [PIXEL_BITS-1:0] a_pix_q;
  pix_ctrl_t             a_ctrl_q;
  logic                  b_vld_q, b_vld_d;
  logic [PIXEL_BITS-1:0] b_pix_q;
  logic                  b_fe_q;
  logic [PIXEL_BITS-1:0] held_q, held_d;
  logic                  a_adv, out_acc;

  assign out_acc    = b_vld_q & ~out_stall_i;
  assign a_adv      = a_vld_q & (~b_vld_q | ~out_stall_i);
  // the store read data stays put while stage A waits, as no new read is issued
  assign in_stall_o = a_vld_q & ~a_adv;

  always_comb begin
    case (a_ctrl_q.kind)
      KIND_DIRECT: held_d = a_pix_q;
      KIND_READ:   held_d = rdata_i;
      default:     held_d = held_q;
    endcase
  end

  assign a_vld_d = in_acc_i | (a_vld_q & ~a_adv);
  assign b_vld_d = a_adv | (b_vld_q & ~out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      held_q  <= '0;
    end else begin
      a_vld_q <= a_vld_d;
      b_vld_q <= b_vld_d;
      if (a_adv) begin
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_i) begin
      a_pix_q  <= pixel_i;
      a_ctrl_q <= ctrl_i;
    end
    if (a_adv) begin
      b_pix_q <= held_d;
      b_fe_q  <= a_ctrl_q.frame_end;
    end
  end

  assign out_valid_o = b_vld_q;
  assign pixel_o     = b_pix_q;
  assign frame_end_o = b_fe_q;

endmodule
`default_nettype wire

@@ sv/pixel_block_mosaic.sv @@
// Top level: register port, position tracking, line store and output pipeline.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o  pixel_in_i, frame_start_i
//   out      source     out_valid_o / out_stall_i pixel_out_o, frame_end_o
//   cfg      APB        psel, penable, pready    paddr, pwdata, prdata
//
// One pixel per clock sustained while the output does not stall; an input transfer
// reaches the output through the read stage, where the line store read is registered,
// and the output register.
// Reset clears position, held value and pipeline valids; the line store is not
// cleared and no clearing pass is run.
// An output stall holds the output register; at most one more pixel is taken into the
// read stage before the input stalls.
`default_nettype none
module pixel_block_mosaic
  import pbm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [PIXEL_BITS-1:0] pixel_in_i,
  input  wire logic                  frame_start_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [PIXEL_BITS-1:0] pixel_out_o,
  output logic                       frame_end_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [DATA_W-1:0]     pwdata,
  output logic      [DATA_W-1:0]     prdata,
  output logic                       pready
);

  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;
  logic [BS_W-1:0] bs_q;
  logic            cfg_wr, in_acc;
  logic [1:0]      reg_idx;

  pix_ctrl_t             ctrl;
  ram_req_t              ram_req;
  logic [PIXEL_BITS-1:0] rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FW_RESET;
      fh_q <= FH_RESET;
      bs_q <= BS_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  fw_q <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_q <= pwdata[FH_W-1:0];
        REG_BLOCK_SIZE:   bs_q <= pwdata[BS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = DATA_W'(fw_q);
      REG_FRAME_HEIGHT: prdata = DATA_W'(fh_q);
      REG_BLOCK_SIZE:   prdata = DATA_W'(bs_q);
      default:          prdata = '0;
    endcase
  end

  assign in_acc = in_valid_i & ~in_stall_o;

  pbm_pos u_pos (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_acc_i       (in_acc),
    .frame_start_i  (frame_start_i),
    .frame_width_i  (fw_q),
    .frame_height_i (fh_q),
    .block_size_i   (bs_q),
    .ctrl_o         (ctrl),
    .ram_req_o      (ram_req)
  );

  pbm_line_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .wdata_i (pixel_in_i),
    .rdata_o (rdata)
  );

  pbm_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_acc_i    (in_acc),
    .pixel_i     (pixel_in_i),
    .ctrl_i      (ctrl),
    .rdata_i     (rdata),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .pixel_o     (pixel_out_o),
    .frame_end_o (frame_end_o)
  );

endmodule
`default_nettype wire

@@ sv/pbm_checker.sv @@
// Port-level checks for the pixel block mosaic, bound to the top level.
`default_nettype none
module pbm_checker
  import pbm_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [PIXEL_BITS-1:0] pixel_out_o
);

  // outputs are quiet once reset has been seen at an edge
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // an empty output side never back-pressures the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // a fresh output must trace back to an input transfer through the read stage and output register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o) && $past(rst_ni, 2)) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("output without matching input transfer");

  // a stalled output holds its pixel
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pixel_out_o)))
    else $error("stalled output changed");

endmodule

bind pixel_block_mosaic pbm_checker u_pbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pixel_out_o (pixel_out_o)
);
`default_nettype wire
